// ===== rtl/core/focpwm_pkg.sv =====
package focpwm_pkg;

   // Angle scale: Q3.12 radians, 2pi and pi/2 as integers
   localparam int unsigned ANGLE_TWO_PI  = 25736;
   localparam int unsigned ANGLE_HALF_PI = 6434;
   localparam int unsigned ANGLE_W       = 15;

   localparam int unsigned SQRT3_Q15 = 56756;
   localparam longint      PI_Q30    = 64'sd3373259426;

   // floor(x / ANGLE_TWO_PI) as a multiply by reciprocal, at most one low
   localparam int unsigned RECIP_SHIFT = 32;
   localparam longint      RECIP_MUL   = (64'sd1 <<< RECIP_SHIFT) / ANGLE_TWO_PI;
   localparam int unsigned RECIP_W     = 18;

   localparam int unsigned SINE_TABLE_DEPTH = 1024;

   localparam logic [15:0] VBUS_RESET   = 16'd3072;
   localparam logic [15:0] PERIOD_RESET = 16'd5600;

   localparam int unsigned CSR_INDEX_W = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_VBUS   = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PERIOD = 8'd1;

   localparam int unsigned DIV_STAGES = 16;

   // Q15 sine of a Q30 angle in [0, 2pi), Taylor series through x^13
   function automatic logic signed [15:0] sine_q15(input longint t_in);
      longint t;
      longint x2;
      longint term;
      longint sum;
      longint s;
      logic   neg;
      t   = t_in;
      neg = 1'b0;
      if (t > PI_Q30) begin
         t   = t - PI_Q30;
         neg = 1'b1;
      end
      if (t > PI_Q30 / 2) begin
         t = PI_Q30 - t;
      end
      if (t < 0) begin
         t = 0;
      end
      x2   = (t * t) >>> 30;
      sum  = t;
      term = ((t * x2) >>> 30) / 6;
      sum  = sum - term;
      term = ((term * x2) >>> 30) / 20;
      sum  = sum + term;
      term = ((term * x2) >>> 30) / 42;
      sum  = sum - term;
      term = ((term * x2) >>> 30) / 72;
      sum  = sum + term;
      term = ((term * x2) >>> 30) / 110;
      sum  = sum - term;
      term = ((term * x2) >>> 30) / 156;
      sum  = sum + term;
      if (sum < 0) begin
         sum = 0;
      end
      s = (sum * 32767 + (64'sd1 <<< 29)) >>> 30;
      if (s > 32767) begin
         s = 32767;
      end
      if (neg) begin
         s = -s;
      end
      return s[15:0];
   endfunction

endpackage

// ===== rtl/core/foc_voltage_to_pwm_compare_unit.sv =====
// Sinusoidal FOC voltage output: each request (uq Q8.8 volts, electrical angle
// Q3.12 radians) yields one response of three PWM compare counts. uq is clamped
// to +/- floor(vbus/2), the angle wrapped into [0, 2pi), sine and cosine read
// from a Q1.15 ROM, then inverse Park (d = 0) and inverse Clarke transforms give
// three phases, each offset by vbus/2, clamped to 0..vbus and scaled to
// phase*period/vbus. With vbus 0 all counts are 0. The pipeline is 25
// stages deep: nine arithmetic stages, then a 16-stage restoring divider, one
// quotient bit per stage. A request can enter every cycle while no response is
// stalled, so sustained rate is one request per clock; a stalled response
// freezes the whole pipeline. Write vbus and the period register only while
// the pipeline is empty.
module foc_voltage_to_pwm_compare_unit #(
   parameter int unsigned SINE_TABLE_DEPTH = focpwm_pkg::SINE_TABLE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] uq, [31:16] angle
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [15:0] compare_a, [31:16] compare_b, [47:32] compare_c
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [focpwm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0] csr_data
);

   localparam int unsigned AW    = focpwm_pkg::ANGLE_W;
   localparam int unsigned IW    = $clog2(SINE_TABLE_DEPTH);
   localparam int unsigned PW    = $clog2(focpwm_pkg::ANGLE_TWO_PI * SINE_TABLE_DEPTH);
   localparam int unsigned RW    = focpwm_pkg::RECIP_W;
   localparam int unsigned QW    = PW + RW;
   localparam int unsigned DS    = focpwm_pkg::DIV_STAGES;
   localparam int unsigned NSTG  = 9 + DS;

   // ---------------------------------------------------------------- registers
   logic [15:0] vbus_ff;
   logic [15:0] period_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vbus_ff   <= focpwm_pkg::VBUS_RESET;
         period_ff <= focpwm_pkg::PERIOD_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            focpwm_pkg::CSR_VBUS:   vbus_ff   <= csr_data;
            focpwm_pkg::CSR_PERIOD: period_ff <= csr_data;
            default: ; // drop writes to unknown registers
         endcase
      end
   end

   // ---------------------------------------------------------------- sine ROM
   logic signed [15:0] sine_rom [SINE_TABLE_DEPTH];

   for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_rom
      localparam longint TK = (2 * focpwm_pkg::PI_Q30 * k) / SINE_TABLE_DEPTH;
      assign sine_rom[k] = focpwm_pkg::sine_q15(TK);
   end

   // ---------------------------------------------------------------- flow
   // The whole pipeline advances together; hold everything while the
   // response waits.
   logic            adv;
   logic [NSTG-1:0] vld_ff;

   assign adv        = !vld_ff[NSTG-1] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[NSTG-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NSTG-2:0], req_tvalid};
      end
   end

   // ---------------------------------------------------------------- stage 1
   // Clamp uq, wrap the angle and its quarter-turn shift.
   logic signed [15:0] uq_req;
   logic signed [16:0] ang_req;
   logic signed [16:0] half_s;
   logic signed [16:0] uq_in;
   logic signed [16:0] a_wrap;
   logic        [AW:0] ac_sum;
   logic [1:0][AW-1:0] ang_in;

   localparam logic signed [16:0] TWO_PI_S  = 17'(focpwm_pkg::ANGLE_TWO_PI);
   localparam logic        [AW:0] TWO_PI_U  = (AW+1)'(focpwm_pkg::ANGLE_TWO_PI);
   localparam logic        [AW:0] HALF_PI_U = (AW+1)'(focpwm_pkg::ANGLE_HALF_PI);

   always_comb begin
      uq_req  = req_tdata[15:0];
      ang_req = 17'(signed'(req_tdata[31:16]));
      half_s  = signed'({2'b00, vbus_ff[15:1]});
      uq_in   = 17'(uq_req);
      if (uq_in > half_s) begin
         uq_in = half_s;
      end else if (uq_in < -half_s) begin
         uq_in = -half_s;
      end
      if (ang_req < -TWO_PI_S) begin
         a_wrap = ang_req + TWO_PI_S + TWO_PI_S;
      end else if (ang_req < 0) begin
         a_wrap = ang_req + TWO_PI_S;
      end else if (ang_req >= TWO_PI_S) begin
         a_wrap = ang_req - TWO_PI_S;
      end else begin
         a_wrap = ang_req;
      end
      ac_sum = {1'b0, a_wrap[AW-1:0]} + HALF_PI_U;
      if (ac_sum >= TWO_PI_U) begin
         ac_sum = ac_sum - TWO_PI_U;
      end
      ang_in[0] = a_wrap[AW-1:0];
      ang_in[1] = ac_sum[AW-1:0];
   end

   logic signed [15:0] uq1_ff;
   logic [1:0][AW-1:0] ang1_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         uq1_ff  <= uq_in[15:0];
         ang1_ff <= ang_in;
      end
   end

   // ---------------------------------------------------------------- stages 2-4
   // Table index floor(a * depth / 2pi) by reciprocal, then one correction.
   logic signed [15:0] uq2_ff, uq3_ff, uq4_ff, uq5_ff;
   logic [1:0][PW-1:0] p2_ff, p3_ff;
   logic [1:0][QW-1:0] prod3_ff;
   logic [1:0][IW-1:0] idx4_ff;
   logic [1:0][IW-1:0] idx_in;
   logic [1:0][PW-1:0] rem_in;

   localparam logic [RW-1:0] RECIP = RW'(focpwm_pkg::RECIP_MUL);
   localparam logic [PW-1:0] TWO_PI_P = PW'(focpwm_pkg::ANGLE_TWO_PI);
   localparam logic [PW-1:0] DEPTH_P  = PW'(SINE_TABLE_DEPTH);

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         idx_in[l] = prod3_ff[l][focpwm_pkg::RECIP_SHIFT +: IW];
         rem_in[l] = p3_ff[l] - PW'(PW'(idx_in[l]) * TWO_PI_P);
         if (rem_in[l] >= TWO_PI_P) begin
            idx_in[l] = idx_in[l] + IW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         uq2_ff <= uq1_ff;
         uq3_ff <= uq2_ff;
         uq4_ff <= uq3_ff;
         uq5_ff <= uq4_ff;
         for (int l = 0; l < 2; l++) begin
            p2_ff[l]    <= PW'(PW'(ang1_ff[l]) * DEPTH_P);
            p3_ff[l]    <= p2_ff[l];
            prod3_ff[l] <= QW'(QW'(p2_ff[l]) * QW'(RECIP));
         end
         idx4_ff <= idx_in;
      end
   end

   // ---------------------------------------------------------------- stage 5
   logic signed [15:0] sin5_ff, cos5_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         sin5_ff <= sine_rom[idx4_ff[0]];
         cos5_ff <= sine_rom[idx4_ff[1]];
      end
   end

   // ---------------------------------------------------------------- stages 6-7
   // Inverse Park with d = 0, then sqrt(3) * ubeta.
   logic signed [31:0] ps6_ff, pc6_ff;
   logic signed [17:0] ualpha_in, ualpha7_ff;
   logic signed [17:0] ubeta_in;
   logic signed [35:0] s3p7_ff;

   localparam logic signed [17:0] SQRT3_S = 18'(focpwm_pkg::SQRT3_Q15);

   assign ualpha_in = -(18'(ps6_ff >>> 15));
   assign ubeta_in  = 18'(pc6_ff >>> 15);

   always_ff @(posedge clock) begin
      if (adv) begin
         ps6_ff     <= 32'(uq5_ff) * 32'(sin5_ff);
         pc6_ff     <= 32'(uq5_ff) * 32'(cos5_ff);
         ualpha7_ff <= ualpha_in;
         s3p7_ff    <= 36'(ubeta_in) * 36'(SQRT3_S);
      end
   end

   // ---------------------------------------------------------------- stage 8
   // Inverse Clarke, offset by vbus/2, clamp to 0..vbus.
   logic signed [21:0] s3b_in;
   logic signed [21:0] half_w;
   logic signed [21:0] vbus_w;
   logic signed [21:0] ph_raw [3];
   logic [2:0][15:0] ph_in;
   logic [2:0][15:0] ph8_ff;

   always_comb begin
      s3b_in    = 22'(s3p7_ff >>> 15);
      half_w    = 22'({1'b0, vbus_ff[15:1]});
      vbus_w    = 22'({1'b0, vbus_ff});
      ph_raw[0] = 22'(ualpha7_ff) + half_w;
      ph_raw[1] = ((s3b_in - 22'(ualpha7_ff)) >>> 1) + half_w;
      ph_raw[2] = ((-22'(ualpha7_ff) - s3b_in) >>> 1) + half_w;
      for (int l = 0; l < 3; l++) begin
         if (ph_raw[l] < 0) begin
            ph_in[l] = '0;
         end else if (ph_raw[l] > vbus_w) begin
            ph_in[l] = vbus_ff;
         end else begin
            ph_in[l] = ph_raw[l][15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ph8_ff <= ph_in;
      end
   end

   // ---------------------------------------------------------------- stage 9
   logic [2:0][31:0] num9_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int l = 0; l < 3; l++) begin
            num9_ff[l] <= 32'(ph8_ff[l]) * 32'(period_ff);
         end
      end
   end

   // ---------------------------------------------------------------- divider
   // Restoring division by vbus, one quotient bit per stage. Each word holds
   // the partial remainder high and the shifting dividend/quotient low. The
   // quotient never exceeds the period, so the top half starts below vbus.
   logic [DS-1:0][2:0][31:0] div_ff;
   logic [DS-1:0][2:0][31:0] div_in;

   always_comb begin
      for (int s = 0; s < DS; s++) begin
         for (int l = 0; l < 3; l++) begin
            logic [31:0] src;
            logic [16:0] trial;
            src   = (s == 0) ? num9_ff[l] : div_ff[(s == 0) ? 0 : s-1][l];
            trial = src[31:15];
            if (trial >= {1'b0, vbus_ff}) begin
               trial = trial - {1'b0, vbus_ff};
               div_in[s][l] = {trial[15:0], src[14:0], 1'b1};
            end else begin
               div_in[s][l] = {trial[15:0], src[14:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         div_ff <= div_in;
      end
   end

   // Zero supply forces all counts to zero.
   logic vbus_zero;
   assign vbus_zero = (vbus_ff == '0);

   assign rsp_tdata = vbus_zero ? '0 :
                      {div_ff[DS-1][2][15:0], div_ff[DS-1][1][15:0], div_ff[DS-1][0][15:0]};

endmodule

// ===== rtl/core/focpwm_checker.sv =====
module focpwm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata
);

   // Pipeline empties on reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // Empty or draining output never blocks a request
   a_accept_free: assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid || rsp_tready) |-> req_tready)
      else $error("request refused with free output");

   // A waiting response freezes the pipeline
   a_stall_freeze: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("request taken during output stall");

   // Stalled response holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled response changed");

endmodule

bind foc_voltage_to_pwm_compare_unit focpwm_checker u_focpwm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
